[rtl/core/escp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_pkg
// Shared types and constants for the encoder step and press classifier.
// ----------------------------------------------------------------------------
package escp_pkg;

   // Field widths
   localparam int CountW   = 16;
   localparam int TimeW    = 32;
   localparam int CfgW     = 16;
   localparam int CpsW     = 8;
   localparam int RemW     = 18;
   localparam int AccW     = 19;
   localparam int ProdW    = CountW + CpsW + 1;
   localparam int DivSteps = AccW;
   localparam int DivCntW  = $clog2(DivSteps);
   localparam int CsrIdxW  = 2;
   localparam int ReqDataW = 56;
   localparam int RspDataW = 24;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_EVENT_GAP  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_CPS        = 2'd3;

   // Reset values of the configuration registers
   localparam logic [CfgW-1:0] DebounceReset  = 16'd20;
   localparam logic [CfgW-1:0] LongPressReset = 16'd600;
   localparam logic [CfgW-1:0] EventGapReset  = 16'd150;
   localparam logic [CpsW-1:0] CpsReset       = 8'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_PREP,
      ST_BUTTON,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } escp_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic prime;
      logic prep;
      logic button;
      logic div_step;
      logic mul;
      logic finish;
   } escp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic primed;
      logic div_last;
      logic out_free;
   } escp_sts_type;

endpackage

[rtl/core/escp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_ctrl
// Sequencer that walks one poll through priming or through the button
// update, the step division, the multiply-back and the final write.
// ----------------------------------------------------------------------------
module escp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  escp_pkg::escp_sts_type sts,
   output escp_pkg::escp_cmd_type cmd
);
   import escp_pkg::*;

   escp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.primed ? ST_PREP : ST_PRIME;
            end
         end
         ST_PRIME: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP:     state_in = ST_BUTTON;
         ST_BUTTON:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_PRIME:    cmd.prime    = sts.out_free;
         ST_PREP:     cmd.prep     = 1'b1;
         ST_BUTTON:   cmd.button   = 1'b1;
         ST_DIVIDE:   cmd.div_step = 1'b1;
         ST_MULTIPLY: cmd.mul      = 1'b1;
         ST_FINISH:   cmd.finish   = sts.out_free;
         default:     cmd          = '0;
      endcase
   end

endmodule

[rtl/core/escp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_datapath
// Poll state, configuration registers, button classifier, bit-serial step
// divider and the output register.
// ----------------------------------------------------------------------------
module escp_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [escp_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [escp_pkg::CfgW-1:0]      csr_wdata,
   input  logic [escp_pkg::ReqDataW-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [escp_pkg::RspDataW-1:0]  rsp_tdata,
   input  escp_pkg::escp_cmd_type         cmd,
   output escp_pkg::escp_sts_type         sts
);
   import escp_pkg::*;

   // Configuration
   logic [CfgW-1:0] db_time_ff, lp_time_ff, gap_time_ff;
   logic [CpsW-1:0] cps_ff;
   logic [CpsW-1:0] cps_eff;

   // Captured poll
   logic [CountW-1:0] raw_ff, raw_in;
   logic              level_ff, level_in;
   logic [TimeW-1:0]  now_ff, now_in;

   // Persistent poll state
   logic                   primed_ff, primed_in;
   logic [CountW-1:0]      prev_count_ff, prev_count_in;
   logic signed [RemW-1:0] rem_ff, rem_in;
   logic                   prev_level_ff, prev_level_in;
   logic                   stable_ff, stable_in;
   logic [TimeW-1:0]       lct_ff, lct_in;
   logic [TimeW-1:0]       pst_ff, pst_in;
   logic                   rec_ff, rec_in;
   logic [TimeW-1:0]       let_ff, let_in;
   logic                   lf_ff, lf_in;
   logic                   await_ff, await_in;

   // Working registers
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic [AccW-1:0]         quot_ff, quot_in;
   logic [CpsW-1:0]         part_ff, part_in;
   logic [DivCntW-1:0]      cnt_ff, cnt_in;
   logic                    db_raw_ff, db_raw_in;
   logic                    lt_raw_ff, lt_raw_in;
   logic                    gap_raw_ff, gap_raw_in;
   logic signed [CountW-1:0] s_ff, s_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic                    short_ff, short_in;
   logic                    long_ff, long_in;

   // Output register
   logic                    out_valid_ff, out_valid_in;
   logic [CountW-1:0]       out_steps_ff, out_steps_in;
   logic                    out_short_ff, out_short_in;
   logic                    out_long_ff, out_long_in;
   logic                    out_pressed_ff, out_pressed_in;

   // Combinational helpers
   logic [CountW-1:0]       delta;
   logic signed [AccW-1:0]  acc_sum;
   logic                    lvl_chg, db_ok, rising;
   logic                    stable_n, rec_n, lf_n, await_n, long_ok;
   logic [CpsW:0]           div_shift;
   logic                    div_bit;
   logic signed [ProdW-1:0] rem_full;
   logic                    out_free;

   assign cps_eff  = (cps_ff == '0) ? {{(CpsW-1){1'b0}}, 1'b1} : cps_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         db_time_ff  <= DebounceReset;
         lp_time_ff  <= LongPressReset;
         gap_time_ff <= EventGapReset;
         cps_ff      <= CpsReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   db_time_ff  <= csr_wdata;
            CSR_LONG_PRESS: lp_time_ff  <= csr_wdata;
            CSR_EVENT_GAP:  gap_time_ff <= csr_wdata;
            CSR_CPS:        cps_ff      <= csr_wdata[CpsW-1:0];
            default:        cps_ff      <= cps_ff;
         endcase
      end
   end

   assign delta     = raw_ff - prev_count_ff;
   assign acc_sum   = AccW'(rem_ff) + AccW'($signed(delta));
   assign div_shift = {part_ff, quot_ff[AccW-1]};
   assign div_bit   = (div_shift >= {1'b0, cps_eff});
   assign rem_full  = ProdW'(acc_ff) - prod_ff;

   // Button classification on the registered time comparisons.
   always_comb begin
      lvl_chg  = (level_ff != prev_level_ff);
      db_ok    = lvl_chg ? (db_time_ff == '0) : db_raw_ff;
      rising   = db_ok && (stable_ff != level_ff) && level_ff;
      stable_n = db_ok ? level_ff : stable_ff;
      rec_n    = rec_ff;
      lf_n     = lf_ff;
      await_n  = await_ff;
      if (db_ok && (stable_ff != level_ff)) begin
         lf_n = 1'b0;
         if (level_ff) begin
            rec_n = 1'b1;
         end else begin
            rec_n   = 1'b0;
            await_n = 1'b0;
         end
      end
      long_ok = db_ok && stable_n && !lf_n && !await_n && rec_n && gap_raw_ff &&
                (rising ? (lp_time_ff == '0) : lt_raw_ff);
   end

   always_comb begin
      raw_in        = raw_ff;
      level_in      = level_ff;
      now_in        = now_ff;
      primed_in     = primed_ff;
      prev_count_in = prev_count_ff;
      rem_in        = rem_ff;
      prev_level_in = prev_level_ff;
      stable_in     = stable_ff;
      lct_in        = lct_ff;
      pst_in        = pst_ff;
      rec_in        = rec_ff;
      let_in        = let_ff;
      lf_in         = lf_ff;
      await_in      = await_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      quot_in       = quot_ff;
      part_in       = part_ff;
      cnt_in        = cnt_ff;
      db_raw_in     = db_raw_ff;
      lt_raw_in     = lt_raw_ff;
      gap_raw_in    = gap_raw_ff;
      s_in          = s_ff;
      prod_in       = prod_ff;
      short_in      = short_ff;
      long_in       = long_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_steps_in  = out_steps_ff;
      out_short_in  = out_short_ff;
      out_long_in   = out_long_ff;
      out_pressed_in = out_pressed_ff;

      if (cmd.capture) begin
         raw_in   = req_tdata[CountW-1:0];
         level_in = req_tdata[CountW];
         now_in   = req_tdata[CountW+TimeW:CountW+1];
      end

      // The first poll only seeds the state and writes a zero-step result beat.
      if (cmd.prime) begin
         primed_in      = 1'b1;
         prev_count_in  = raw_ff;
         prev_level_in  = level_ff;
         stable_in      = level_ff;
         lct_in         = now_ff;
         pst_in         = '0;
         rec_in         = 1'b0;
         let_in         = '0;
         lf_in          = 1'b0;
         await_in       = 1'b0;
         out_valid_in   = 1'b1;
         out_steps_in   = '0;
         out_short_in   = 1'b0;
         out_long_in    = 1'b0;
         out_pressed_in = level_ff;
      end

      if (cmd.prep) begin
         prev_count_in = raw_ff;
         acc_in        = acc_sum;
         neg_in        = acc_sum[AccW-1];
         quot_in       = acc_sum[AccW-1] ? AccW'(-acc_sum) : AccW'(acc_sum);
         part_in       = '0;
         cnt_in        = '0;
         db_raw_in     = ((now_ff - lct_ff) >= TimeW'(db_time_ff));
         lt_raw_in     = ((now_ff - pst_ff) >= TimeW'(lp_time_ff));
         gap_raw_in    = ((now_ff - let_ff) > TimeW'(gap_time_ff));
      end

      if (cmd.button) begin
         prev_level_in = level_ff;
         if (lvl_chg) begin
            lct_in = now_ff;
         end
         short_in  = 1'b0;
         long_in   = long_ok;
         stable_in = stable_n;
         rec_in    = rec_n;
         lf_in     = lf_n;
         await_in  = await_n;
         if (db_ok && (stable_ff != level_ff)) begin
            if (level_ff) begin
               pst_in = now_ff;
            end else begin
               pst_in = '0;
               if (!await_ff && rec_ff && !lf_ff && gap_raw_ff) begin
                  short_in = 1'b1;
                  let_in   = now_ff;
               end
            end
         end
         if (long_ok) begin
            lf_in    = 1'b1;
            await_in = 1'b1;
            let_in   = now_ff;
         end
      end

      // One quotient bit per cycle, restoring form on the magnitude.
      if (cmd.div_step) begin
         part_in = div_bit ? CpsW'(div_shift - {1'b0, cps_eff}) : div_shift[CpsW-1:0];
         quot_in = {quot_ff[AccW-2:0], div_bit};
         cnt_in  = cnt_ff + 1'b1;
      end

      if (cmd.mul) begin
         if (!neg_ff && (quot_ff > AccW'(32767))) begin
            s_in = 16'sh7FFF;
         end else if (neg_ff && (quot_ff > AccW'(32768))) begin
            s_in = 16'sh8000;
         end else if (neg_ff) begin
            s_in = -$signed(quot_ff[CountW-1:0]);
         end else begin
            s_in = $signed(quot_ff[CountW-1:0]);
         end
         prod_in = ProdW'(s_in) * ProdW'($signed({1'b0, cps_eff}));
      end

      if (cmd.finish) begin
         rem_in         = rem_full[RemW-1:0];
         out_valid_in   = 1'b1;
         out_steps_in   = s_ff;
         out_short_in   = short_ff;
         out_long_in    = long_ff;
         out_pressed_in = stable_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff     <= 1'b0;
         prev_count_ff <= '0;
         rem_ff        <= '0;
         prev_level_ff <= 1'b0;
         stable_ff     <= 1'b0;
         lct_ff        <= '0;
         pst_ff        <= '0;
         rec_ff        <= 1'b0;
         let_ff        <= '0;
         lf_ff         <= 1'b0;
         await_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         primed_ff     <= primed_in;
         prev_count_ff <= prev_count_in;
         rem_ff        <= rem_in;
         prev_level_ff <= prev_level_in;
         stable_ff     <= stable_in;
         lct_ff        <= lct_in;
         pst_ff        <= pst_in;
         rec_ff        <= rec_in;
         let_ff        <= let_in;
         lf_ff         <= lf_in;
         await_ff      <= await_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff         <= raw_in;
      level_ff       <= level_in;
      now_ff         <= now_in;
      acc_ff         <= acc_in;
      neg_ff         <= neg_in;
      quot_ff        <= quot_in;
      part_ff        <= part_in;
      cnt_ff         <= cnt_in;
      db_raw_ff      <= db_raw_in;
      lt_raw_ff      <= lt_raw_in;
      gap_raw_ff     <= gap_raw_in;
      s_ff           <= s_in;
      prod_ff        <= prod_in;
      short_ff       <= short_in;
      long_ff        <= long_in;
      out_steps_ff   <= out_steps_in;
      out_short_ff   <= out_short_in;
      out_long_ff    <= out_long_in;
      out_pressed_ff <= out_pressed_in;
   end

   assign sts.primed   = primed_ff;
   assign sts.div_last = (cnt_ff == DivCntW'(DivSteps - 1));
   assign sts.out_free = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW-CountW-3){1'b0}}, out_pressed_ff, out_long_ff,
                        out_short_ff, out_steps_ff};

endmodule

[rtl/core/encoder_step_and_press_classifier.sv]
`timescale 1ns / 1ps
// Flow: a priming poll's result beat is written to the output register from the prime
// state; any later poll's goes through prep, button update, the step divider (one
// quotient bit per cycle), multiply and the final write, each write waiting for a free
// output register. The next beat is taken only once the
// previous one has been written to the output register.
// Reset: synchronous, active high; configuration returns to its defaults.
// ----------------------------------------------------------------------------
// encoder_step_and_press_classifier
// Turns encoder counts into whole steps and classifies debounced button
// presses as short or long, one result beat per poll beat.
// ----------------------------------------------------------------------------
module encoder_step_and_press_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [escp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [escp_pkg::CfgW-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // raw_count[15:0], button_level[16], now_ms[48:17], zero fill
   input  logic [escp_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // steps[15:0], short_press[16], long_press[17], pressed[18], zero fill
   output logic [escp_pkg::RspDataW-1:0] rsp_tdata
);
   import escp_pkg::*;

   escp_cmd_type cmd;
   escp_sts_type sts;

   escp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   escp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // At most one sequencer command is active in any cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command active");

   // The divider never runs while a new beat may be taken.
   a_idle_no_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.div_step)
      else $error("divider stepping while idle");

   // A poll never reports a short and a long press together.
   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[CountW] && rsp_tdata[CountW+1]))
      else $error("short and long press in the same beat");

   // A final or priming write always presents a result beat on the next cycle.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.prime) |=> rsp_tvalid)
      else $error("result lost after final write");

endmodule

[test/press_step_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_step_checker
// Watches the poll, result and register channels of the encoder step and
// press classifier. It predicts the steps, the button events and the
// debounced level for every accepted poll and compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module press_step_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [escp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [escp_pkg::CfgW-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // raw_count[15:0], button_level[16], now_ms[48:17], zero fill
   input  logic [escp_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // steps[15:0], short_press[16], long_press[17], pressed[18], zero fill
   input  logic [escp_pkg::RspDataW-1:0] rsp_tdata,
   output int                            outstanding,
   output int                            mismatches
);
   import escp_pkg::*;

   typedef struct packed {
      logic [CountW-1:0] steps;
      logic              short_press;
      logic              long_press;
      logic              pressed;
   } poll_outcome_type;

   // Register copies
   logic [CfgW-1:0]   debounce_window;
   logic [CfgW-1:0]   long_press_ms;
   logic [CfgW-1:0]   gap_ms;
   logic [CpsW-1:0]   step_size;

   // Classifier state
   logic              primed;
   logic [CountW-1:0] prev_count;
   int                leftover_counts;
   logic              prev_level;
   logic              stable_level;
   logic [TimeW-1:0]  change_time;
   logic [TimeW-1:0]  press_start;
   logic              press_recorded;
   logic [TimeW-1:0]  last_event;
   logic              long_fired;
   logic              await_release;

   poll_outcome_type  due_outcomes[$];
   int                beats_seen;

   function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] later,
                                                 input logic [TimeW-1:0] earlier);
      return later - earlier;
   endfunction

   task automatic report(input string msg);
      $display("[%0t] result beat %0d mismatch: %s", $realtime, beats_seen, msg);
      mismatches++;
   endtask

   task automatic classify_poll(input logic [CountW-1:0] raw, input logic level,
                                input logic [TimeW-1:0] now,
                                output poll_outcome_type res);
      logic [CountW-1:0] diff;
      int                divisor;
      int                total;
      int                whole;
      res = '0;
      if (!primed) begin
         // The first poll only takes the count, level and time as a baseline.
         primed         = 1'b1;
         prev_count     = raw;
         prev_level     = level;
         stable_level   = level;
         change_time    = now;
         press_start    = '0;
         press_recorded = 1'b0;
         last_event     = '0;
         long_fired     = 1'b0;
         await_release  = 1'b0;
      end else begin
         diff    = raw - prev_count;
         divisor = (step_size == 0) ? 1 : int'(step_size);
         total   = leftover_counts + int'(signed'(diff));
         whole   = total / divisor;
         if (whole > 32767) whole = 32767;
         if (whole < -32768) whole = -32768;
         prev_count      = raw;
         leftover_counts = total - whole * divisor;
         res.steps       = whole[CountW-1:0];

         if (level != prev_level) begin
            prev_level  = level;
            change_time = now;
         end

         if (elapsed(now, change_time) >= {16'd0, debounce_window}) begin
            if (stable_level != prev_level) begin
               stable_level = prev_level;
               if (stable_level) begin
                  press_start    = now;
                  press_recorded = 1'b1;
                  long_fired     = 1'b0;
               end else begin
                  // A release right after a long press is swallowed.
                  if (await_release) begin
                     await_release = 1'b0;
                  end else if (press_recorded && !long_fired &&
                               elapsed(now, last_event) > {16'd0, gap_ms}) begin
                     res.short_press = 1'b1;
                     last_event      = now;
                  end
                  press_recorded = 1'b0;
                  press_start    = '0;
                  long_fired     = 1'b0;
               end
            end

            if (stable_level && !long_fired && !await_release && press_recorded &&
                elapsed(now, press_start) >= {16'd0, long_press_ms} &&
                elapsed(now, last_event) > {16'd0, gap_ms}) begin
               res.long_press = 1'b1;
               long_fired     = 1'b1;
               await_release  = 1'b1;
               last_event     = now;
            end
         end
      end
      res.pressed = stable_level;
   endtask

   always @(posedge clock) begin
      poll_outcome_type fresh;
      poll_outcome_type oldest;
      poll_outcome_type seen;
      if (reset) begin
         debounce_window = DebounceReset;
         long_press_ms   = LongPressReset;
         gap_ms          = EventGapReset;
         step_size       = CpsReset;
         primed          = 1'b0;
         prev_count      = '0;
         leftover_counts = 0;
         prev_level      = 1'b0;
         stable_level    = 1'b0;
         change_time     = '0;
         press_start     = '0;
         press_recorded  = 1'b0;
         last_event      = '0;
         long_fired      = 1'b0;
         await_release   = 1'b0;
         beats_seen      = 0;
         due_outcomes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEBOUNCE:   debounce_window = csr_wdata;
               CSR_LONG_PRESS: long_press_ms   = csr_wdata;
               CSR_EVENT_GAP:  gap_ms          = csr_wdata;
               CSR_CPS:        step_size       = csr_wdata[CpsW-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            seen.steps       = rsp_tdata[15:0];
            seen.short_press = rsp_tdata[16];
            seen.long_press  = rsp_tdata[17];
            seen.pressed     = rsp_tdata[18];
            if (due_outcomes.size() == 0) begin
               report("result beat with no poll outstanding");
            end else begin
               oldest = due_outcomes.pop_front();
               if (seen.steps !== oldest.steps)
                  report($sformatf("steps expected %0d, got %0d",
                                   $signed(oldest.steps), $signed(seen.steps)));
               if (seen.short_press !== oldest.short_press)
                  report($sformatf("short_press expected %b, got %b",
                                   oldest.short_press, seen.short_press));
               if (seen.long_press !== oldest.long_press)
                  report($sformatf("long_press expected %b, got %b",
                                   oldest.long_press, seen.long_press));
               if (seen.pressed !== oldest.pressed)
                  report($sformatf("pressed expected %b, got %b",
                                   oldest.pressed, seen.pressed));
            end
            beats_seen++;
         end

         if (req_tvalid && req_tready) begin
            classify_poll(req_tdata[15:0], req_tdata[16], req_tdata[48:17], fresh);
            due_outcomes.push_back(fresh);
         end
      end
      outstanding <= due_outcomes.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives polls and register writes into the encoder step and press
// classifier: a directed opening on count wrap, debounce, short and long
// presses, step saturation and a zero step size, then random press and
// release gestures with bounce under several register settings. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import escp_pkg::*;

   localparam int CycleLimit = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CfgW-1:0]     csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // raw_count[15:0], button_level[16], now_ms[48:17], zero fill
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // steps[15:0], short_press[16], long_press[17], pressed[18], zero fill
   logic [RspDataW-1:0] rsp_tdata;

   int                  outstanding;
   int                  mismatches;
   int                  cycles = 0;
   int                  stall_left = 0;
   int                  polls_sent = 0;
   bit                  quiet = 1'b0;

   // Stimulus view of time, count and the current register values
   logic [TimeW-1:0]    now_ms = '0;
   logic [CountW-1:0]   raw_now = '0;
   int                  db = int'(DebounceReset);
   int                  lp = int'(LongPressReset);
   int                  gap = int'(EventGapReset);

   encoder_step_and_press_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   press_step_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("encoder_step_and_press_classifier regression: fail");
         $finish;
      end
   end

   // Result side back-pressure in short bursts.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (!quiet && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 3);
      rsp_tready <= quiet || (stall_left == 0);
   end

   task automatic poll(input logic [CountW-1:0] raw, input logic level,
                       input logic [TimeW-1:0] dt);
      now_ms  = now_ms + dt;
      raw_now = raw;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now_ms, level, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      polls_sent++;
   endtask

   // Waits until every poll has its result beat and the block has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input int d, input int l, input int g, input int c);
      drain();
      db  = d;
      lp  = l;
      gap = g;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= 16'(d);
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= 16'(l);
      @(posedge clock);
      csr_index <= CSR_EVENT_GAP;
      csr_wdata <= 16'(g);
      @(posedge clock);
      csr_index <= CSR_CPS;
      csr_wdata <= 16'(c);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Time steps sized to land around the debounce, long press and gap limits.
   function automatic logic [TimeW-1:0] pick_dt();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 3);
         2, 3, 4: return $urandom_range(0, db + db / 2 + 2);
         5, 6:    return $urandom_range(0, lp + lp / 4 + 2);
         7, 8:    return $urandom_range(0, gap + gap / 4 + 2);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CountW-1:0] pick_delta();
      case ($urandom_range(0, 7))
         0, 1, 2, 3, 4: return 16'($urandom_range(0, 20) - 10);
         5, 6:          return 16'($urandom_range(0, 1023) - 512);
         default:       return 16'($urandom);
      endcase
   endfunction

   // A few bouncing polls, then the button held at the target level.
   task automatic gesture(input logic target);
      logic bounce_level;
      repeat ($urandom_range(0, 3)) begin
         bounce_level = 1'($urandom_range(0, 1));
         poll(raw_now + pick_delta(), bounce_level, $urandom_range(0, db / 2 + 1));
      end
      repeat ($urandom_range(1, 4))
         poll(raw_now + pick_delta(), target, pick_dt());
   endtask

   initial begin
      int   phase_end;
      logic level_goal;
      logic noise_level;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults. Priming with the button already held, near the time wrap.
      now_ms = 32'hFFFF_FF00;
      poll(16'h8000, 1'b1, 0);
      poll(16'h0000, 1'b1, 700);
      poll(16'h7FFF, 1'b1, 10);
      poll(16'h7FFF, 1'b0, 30);
      poll(16'h7FFE, 1'b0, 25);
      // Clean short press.
      poll(16'h7FFE, 1'b1, 5);
      poll(16'h7FFE, 1'b1, 25);
      poll(16'h7FFE, 1'b0, 100);
      poll(16'h8001, 1'b0, 21);
      // Second press inside the event gap gives no event.
      poll(16'h8001, 1'b1, 1);
      poll(16'h8001, 1'b1, 20);
      poll(16'h8001, 1'b0, 10);
      poll(16'h8001, 1'b0, 20);
      // Long press one millisecond short of the limit, then at it.
      poll(16'h8001, 1'b1, 200);
      poll(16'h8001, 1'b1, 20);
      poll(16'h8001, 1'b1, 599);
      poll(16'h8001, 1'b1, 1);
      poll(16'h7FFC, 1'b0, 50);
      poll(16'h7FFC, 1'b0, 20);
      poll(16'hFFFF, 1'b1, 32'hFFFF_FFFF - now_ms);
      poll(16'h0000, 1'b1, 1);

      // Step saturation in both directions after lowering the step size.
      configure(db, lp, gap, 1);
      poll(raw_now, 1'b0, 30);
      configure(db, lp, gap, 255);
      poll(raw_now + 16'd254, 1'b0, 3);
      configure(db, lp, gap, 1);
      poll(raw_now + 16'h7FFF, 1'b0, 3);
      poll(raw_now, 1'b0, 3);
      configure(db, lp, gap, 255);
      poll(raw_now - 16'd254, 1'b0, 3);
      configure(db, lp, gap, 1);
      poll(raw_now + 16'h8000, 1'b0, 3);

      // All times zero and a step size of zero.
      configure(0, 0, 0, 0);
      poll(raw_now + 16'd7, 1'b0, 3);
      poll(raw_now - 16'd3, 1'b1, 0);
      poll(raw_now, 1'b0, 0);
      poll(raw_now, 1'b1, 0);
      poll(raw_now, 1'b1, 1);
      poll(raw_now, 1'b0, 1);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(int'(DebounceReset), int'(LongPressReset),
                         int'(EventGapReset), int'(CpsReset));
            1: configure(0, 0, 0, 1);
            2: configure(65535, 65535, 65535, 255);
            3: configure(3, 40, 10, 2);
            4: configure($urandom_range(0, 60), $urandom_range(0, 800),
                         $urandom_range(0, 300), $urandom_range(1, 255));
            default: configure(10, 100, 30, 3);
         endcase
         // The closing stretch runs without idling on either side.
         quiet      = (phase == 5);
         level_goal = 1'b1;
         phase_end  = polls_sent + 270;
         while (polls_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               noise_level = 1'($urandom_range(0, 1));
               poll(raw_now + pick_delta(), noise_level, pick_dt());
            end else begin
               gesture(level_goal);
               level_goal = ~level_goal;
            end
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("encoder_step_and_press_classifier regression: pass");
      else
         $display("encoder_step_and_press_classifier regression: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/escp_pkg.sv
rtl/core/escp_ctrl.sv
rtl/core/escp_datapath.sv
rtl/core/encoder_step_and_press_classifier.sv
test/press_step_checker.sv
test/tb_top.sv
